FILE: hw/rtl/rounded_card_pixel_shader_core_defines.svh
// ----------------------------------------------------------------------------
// Rounded card pixel shader: assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ROUNDED_CARD_PIXEL_SHADER_CORE_DEFINES_SVH
`define ROUNDED_CARD_PIXEL_SHADER_CORE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define RCPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define RCPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rcps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcps_pkg
// Widths, register codes and word types of the rounded card pixel shader.
// ----------------------------------------------------------------------------
package rcps_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 4;

    localparam int FIELD_W    = 12;
    localparam int DIM_W      = 12;
    localparam int RAD_W      = 11;
    localparam int RGB_W      = 24;
    localparam int STRIPE_W   = 8;
    localparam int COORD_USE  = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;

    // |pixel centre| < 2^(DIM_W+F); q = |p| - h + r stays below 2^(DIM_W+F+1)
    localparam int ABS_W      = DIM_W + FRAC_BITS;
    localparam int LEN_W      = DIM_W + FRAC_BITS + 2;
    localparam int OUT_W      = DIM_W + FRAC_BITS + 1;
    localparam int ROOT_W     = OUT_W + 1;
    localparam int RAD2_W     = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int DIST_W     = ROOT_W + 2;
    localparam int COV_W      = DIST_W + 1;
    localparam int NUM_CELLS  = ROOT_W;
    localparam int ALPHA_W    = 8;

    localparam int HALF_UNIT  = 1 << (FRAC_BITS - 1);
    localparam int ONE_UNIT   = 1 << FRAC_BITS;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_CARD_WIDTH    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CARD_HEIGHT   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CORNER_RADIUS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FILL_COLOR    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RIM_COLOR     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCENT_COLOR  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_STRIPE_WIDTH  = 3'd6;

    typedef logic signed [LEN_W-1:0]  t_len;
    typedef logic signed [DIST_W-1:0] t_dist;
    typedef logic signed [COV_W-1:0]  t_cov;

    typedef struct packed {
        logic [DIM_W-1:0]    card_width;
        logic [DIM_W-1:0]    card_height;
        logic [RAD_W-1:0]    corner_radius;
        logic [RGB_W-1:0]    fill_color;
        logic [RGB_W-1:0]    rim_color;
        logic [RGB_W-1:0]    accent_color;
        logic [STRIPE_W-1:0] stripe_width;
    } t_cfg;

    // Word moving down the square-root chain, with side data riding along
    typedef struct packed {
        logic [RAD2_W-1:0] radicand;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        t_len              inner;
        logic              stripe;
    } t_root_word;

endpackage

FILE: hw/rtl/rcps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcps_front
// Pixel centre, box excess per axis and the sum of squares (four stages).
// ----------------------------------------------------------------------------
module rcps_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [rcps_pkg::FIELD_W-1:0] i_column,
    input  logic [rcps_pkg::FIELD_W-1:0] i_line_index,
    input  rcps_pkg::t_cfg              i_cfg,
    output logic                        o_valid,
    output rcps_pkg::t_root_word        o_word
);
    import rcps_pkg::*;

    logic [COORD_USE-1:0] col_m, row_m;
    t_len                 px, py, nx, ny;
    logic [ABS_W-1:0]     ax, ay;
    logic                 stripe;

    logic [ABS_W-1:0]     r_ax, r_ay;
    logic                 r_stripe1, r_v1;

    t_len                 hw, hh, rr, qx, qy, qmax;
    logic [OUT_W-1:0]     ox, oy;
    t_len                 inner;

    logic [OUT_W-1:0]     r_ox, r_oy;
    t_len                 r_inside2, r_inside3, r_inside4;
    logic                 r_stripe2, r_stripe3, r_stripe4, r_v2, r_v3, r_v4;

    logic [2*OUT_W-1:0]   sq_x, sq_y;
    logic [2*OUT_W-1:0]   r_sqx, r_sqy;
    logic [RAD2_W-1:0]    r_sum;

    // Stage 1: centre offset (2*c + 1 - w) * half unit, then magnitude
    always_comb begin
        col_m  = i_column[COORD_USE-1:0];
        row_m  = i_line_index[COORD_USE-1:0];
        px     = (t_len'({1'b0, col_m, 1'b1}) - t_len'({1'b0, i_cfg.card_width}))
                 <<< (FRAC_BITS - 1);
        py     = (t_len'({1'b0, row_m, 1'b1}) - t_len'({1'b0, i_cfg.card_height}))
                 <<< (FRAC_BITS - 1);
        nx     = -px;
        ny     = -py;
        ax     = px[LEN_W-1] ? nx[ABS_W-1:0] : px[ABS_W-1:0];
        ay     = py[LEN_W-1] ? ny[ABS_W-1:0] : py[ABS_W-1:0];
        stripe = FIELD_W'(col_m) < FIELD_W'(i_cfg.stripe_width);
    end

    // Stage 2: q = |p| - h + r, outside part per axis, inside part
    always_comb begin
        hw     = t_len'({1'b0, i_cfg.card_width})    <<< (FRAC_BITS - 1);
        hh     = t_len'({1'b0, i_cfg.card_height})   <<< (FRAC_BITS - 1);
        rr     = t_len'({1'b0, i_cfg.corner_radius}) <<< FRAC_BITS;
        qx     = t_len'({1'b0, r_ax}) - hw + rr;
        qy     = t_len'({1'b0, r_ay}) - hh + rr;
        ox     = (qx > 0) ? qx[OUT_W-1:0] : '0;
        oy     = (qy > 0) ? qy[OUT_W-1:0] : '0;
        qmax   = (qx > qy) ? qx : qy;
        inner  = qmax[LEN_W-1] ? qmax : '0;
    end

    // Stage 3: squares
    always_comb begin
        sq_x = r_ox * r_ox;
        sq_y = r_oy * r_oy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax      <= ax;
            r_ay      <= ay;
            r_stripe1 <= stripe;
            r_ox      <= ox;
            r_oy      <= oy;
            r_inside2 <= inner;
            r_stripe2 <= r_stripe1;
            r_sqx     <= sq_x;
            r_sqy     <= sq_y;
            r_inside3 <= r_inside2;
            r_stripe3 <= r_stripe2;
            r_sum     <= RAD2_W'(r_sqx) + RAD2_W'(r_sqy);
            r_inside4 <= r_inside3;
            r_stripe4 <= r_stripe3;
        end
    end

    always_comb begin
        o_valid         = r_v4;
        o_word.radicand = r_sum;
        o_word.rem      = '0;
        o_word.root     = '0;
        o_word.inner    = r_inside4;
        o_word.stripe   = r_stripe4;
    end

endmodule

FILE: hw/rtl/rcps_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcps_sqrt_cell
// One digit of the restoring square root: takes two radicand bits, yields
// one root bit, and hands the word to the next cell.
// ----------------------------------------------------------------------------
module rcps_sqrt_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  rcps_pkg::t_root_word i_word,
    output logic                 o_valid,
    output rcps_pkg::t_root_word o_word
);
    import rcps_pkg::*;

    logic [REM_W-1:0] rem_sh, trial, rem_sub;
    logic             take;
    t_root_word       n_word;
    t_root_word       r_word;
    logic             r_valid;

    always_comb begin
        rem_sh  = {i_word.rem[REM_W-3:0], i_word.radicand[RAD2_W-1 -: 2]};
        trial   = {i_word.root, 2'b01};
        rem_sub = rem_sh - trial;
        take    = rem_sh >= trial;

        n_word          = i_word;
        n_word.radicand = {i_word.radicand[RAD2_W-3:0], 2'b00};
        n_word.rem      = take ? rem_sub : rem_sh;
        n_word.root     = {i_word.root[ROOT_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: hw/rtl/rcps_shade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcps_shade
// Distance, coverage, alpha and colour pick; ends in the output register.
// ----------------------------------------------------------------------------
module rcps_shade (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  rcps_pkg::t_root_word            i_word,
    input  rcps_pkg::t_cfg                  i_cfg,
    output logic                            o_valid,
    output logic                            o_covered,
    output logic [rcps_pkg::OUT_DATA_W-1:0] o_pixel_argb
);
    import rcps_pkg::*;

    localparam int AF_W = FRAC_BITS + 9;

    t_dist               sdist;
    t_dist               r_dist;
    logic                r_stripe, r_v1;

    t_cov                cov;
    logic                covered;
    logic [FRAC_BITS:0]  cov_c;
    logic [AF_W-1:0]     alpha_full;
    logic [ALPHA_W-1:0]  alpha;
    logic [RGB_W-1:0]    rgb;

    logic                r_valid, r_covered;
    logic [OUT_DATA_W-1:0] r_argb;

    // d = outside + inside - r
    always_comb begin
        sdist = t_dist'({1'b0, i_word.root}) + t_dist'(i_word.inner)
              - t_dist'({1'b0, i_cfg.corner_radius, FRAC_BITS'(0)});
    end

    always_comb begin
        cov        = t_cov'(HALF_UNIT) - t_cov'(r_dist);
        covered    = cov > 0;
        cov_c      = (cov > t_cov'(ONE_UNIT)) ? (FRAC_BITS + 1)'(ONE_UNIT)
                                               : cov[FRAC_BITS:0];
        // cov * 255 + half, rounded half up
        alpha_full = AF_W'({cov_c, 8'h00}) - AF_W'(cov_c) + AF_W'(HALF_UNIT);
        alpha      = alpha_full[AF_W-1] ? {ALPHA_W{1'b1}}
                                        : alpha_full[AF_W-2:FRAC_BITS];
        if (r_stripe) begin
            rgb = i_cfg.accent_color;
        end else if (r_dist > t_dist'(-3 * HALF_UNIT)) begin
            rgb = i_cfg.rim_color;
        end else begin
            rgb = i_cfg.fill_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist    <= sdist;
            r_stripe  <= i_word.stripe;
            r_covered <= covered;
            r_argb    <= covered ? {alpha, rgb} : '0;
        end
    end

    assign o_valid      = r_valid;
    assign o_covered    = r_covered;
    assign o_pixel_argb = r_argb;

endmodule

FILE: hw/rtl/rounded_card_pixel_shader_core.sv
`timescale 1ns / 1ps
// Pipe from an accepted input word to its result word: 4 geometry
//   stages, 18 square-root cells, 2 shading stages.
// Throughput: one pixel per clock; the whole pipe stalls only while the
//   output word is held by backpressure.
// Reset (synchronous, active low) empties the pipe and loads the register
//   defaults: 360 x 56 card, radius 12, stripe 3, black colours.
// ----------------------------------------------------------------------------
// rounded_card_pixel_shader_core
// Antialiased rounded-card ARGB shader, one card-local pixel per word.
// ----------------------------------------------------------------------------
module rounded_card_pixel_shader_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rcps_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rcps_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [11:0] column, [23:12] line_index
    input  logic [rcps_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [31:0] pixel_argb
    output logic [rcps_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // [0] covered
    output logic                            o_m_axis_tuser
);
    import rcps_pkg::*;

    t_cfg       r_cfg;
    logic       en;
    logic       front_valid;
    t_root_word front_word;
    logic       cell_valid [NUM_CELLS+1];
    t_root_word cell_word  [NUM_CELLS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.card_width    <= DIM_W'(360);
            r_cfg.card_height   <= DIM_W'(56);
            r_cfg.corner_radius <= RAD_W'(12);
            r_cfg.fill_color    <= '0;
            r_cfg.rim_color     <= '0;
            r_cfg.accent_color  <= '0;
            r_cfg.stripe_width  <= STRIPE_W'(3);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CARD_WIDTH:    r_cfg.card_width    <= i_cfg_wdata[DIM_W-1:0];
                CFG_CARD_HEIGHT:   r_cfg.card_height   <= i_cfg_wdata[DIM_W-1:0];
                CFG_CORNER_RADIUS: r_cfg.corner_radius <= i_cfg_wdata[RAD_W-1:0];
                CFG_FILL_COLOR:    r_cfg.fill_color    <= i_cfg_wdata[RGB_W-1:0];
                CFG_RIM_COLOR:     r_cfg.rim_color     <= i_cfg_wdata[RGB_W-1:0];
                CFG_ACCENT_COLOR:  r_cfg.accent_color  <= i_cfg_wdata[RGB_W-1:0];
                CFG_STRIPE_WIDTH:  r_cfg.stripe_width  <= i_cfg_wdata[STRIPE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // advance everything unless a finished word is waiting downstream
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    rcps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_s_axis_tvalid),
        .i_column     (i_s_axis_tdata[FIELD_W-1:0]),
        .i_line_index (i_s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .i_cfg        (r_cfg),
        .o_valid      (front_valid),
        .o_word       (front_word)
    );

    assign cell_valid[0] = front_valid;
    assign cell_word[0]  = front_word;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        rcps_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cell_valid[g]),
            .i_word  (cell_word[g]),
            .o_valid (cell_valid[g+1]),
            .o_word  (cell_word[g+1])
        );
    end

    rcps_shade u_shade (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (cell_valid[NUM_CELLS]),
        .i_word       (cell_word[NUM_CELLS]),
        .i_cfg        (r_cfg),
        .o_valid      (o_m_axis_tvalid),
        .o_covered    (o_m_axis_tuser),
        .o_pixel_argb (o_m_axis_tdata)
    );

endmodule

FILE: hw/rtl/rcps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcps_checker
// Port-level checks of the shader core, bound to the top level.
// ----------------------------------------------------------------------------
`include "rounded_card_pixel_shader_core_defines.svh"

module rcps_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [rcps_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tuser
);
    import rcps_pkg::*;

    `RCPS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled output word changed")
    `RCPS_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready, "input not ready while output register empty")
    `RCPS_ASSERT_IMP(a_uncovered_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata == '0, "uncovered pixel with nonzero ARGB")
    `RCPS_ASSERT_IMP(a_covered_alpha, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata[OUT_DATA_W-1 -: ALPHA_W] != '0, "covered pixel with zero alpha")

endmodule

bind rounded_card_pixel_shader_core rcps_checker u_rcps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
